@@ design/ppsq_pkg.sv @@
//==============================================================================
// ppsq_pkg
// Types and codes shared by the priority packet send queues.
//==============================================================================
package ppsq_pkg;

    localparam int ID_SPACE = 256;

    localparam logic [1:0] ACT_OFFER = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_COMMAND  = 2'd1;
    localparam logic [1:0] KIND_ACK      = 2'd2;
    localparam logic [1:0] KIND_RESPONSE = 2'd3;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_SEND    = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;
    localparam logic [1:0] EV_EXPIRED = 2'd3;

    localparam logic [1:0] Q_RELAY    = 2'd0;
    localparam logic [1:0] Q_RESPONSE = 2'd1;
    localparam logic [1:0] Q_COMMAND  = 2'd2;
    localparam logic [1:0] Q_NONE     = 2'd3;

    localparam logic [1:0] REG_NODE_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_QUEUE_CAPACITY = 2'd1;
    localparam logic [1:0] REG_MAX_SENDS      = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  pkt_id;
        logic [1:0]  packet_kind;
        logic [7:0]  hop_limit;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic [7:0]  payload_slot;
        logic [7:0]  acked_id;
    } ppsq_in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [1:0]  from_queue;
        logic [7:0]  out_id;
        logic [1:0]  out_kind;
        logic [7:0]  out_hop_limit;
        logic [15:0] out_source;
        logic [15:0] out_dest;
        logic [15:0] out_last_hop;
        logic [7:0]  out_slot;
        logic        accepted;
        logic        pending;
    } ppsq_out_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [1:0]  kind;
        logic [7:0]  ttl;
        logic [15:0] src;
        logic [15:0] dst;
        logic [7:0]  slot;
    } ppsq_desc_t;

endpackage

@@ design/priority_packet_send_queues_unit.sv @@
//==============================================================================
// priority_packet_send_queues_unit
// Three descriptor queues sharing one strict-priority transmit scheduler.
//==============================================================================
// Usage: an item (offer, acknowledge or service tick) is taken when start is
// high and busy is low; busy then stays high until the single result beat has
// been shown on result with done high for one cycle. The receiver cannot stall.
// All three queues live in one descriptor memory (one row region per queue)
// with a registered read; send counts live in a second memory.
// Steps after an item is taken: an offer goes S_READ then S_DONE; a relay or
// response tick S_READ, S_TICK, S_DONE; a command tick passes S_TICK twice
// (descriptor read, then count read); a tick with all queues empty or an
// unused action goes S_READ then S_DONE. An acknowledge over the queued
// commands searches one entry a cycle; on a match each later entry is moved
// down one row by a read/write pair through the single memory port. The next
// item can be taken in the cycle after the result beat.
// After reset the send count memory is cleared, one entry a cycle; busy is
// high meanwhile and configuration writes are still taken (cfg_ready is always
// high). Registers reset to node 0, capacity 16 and five sends.
//==============================================================================
module priority_packet_send_queues_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ppsq_pkg::ppsq_in_t    operand,
    output logic                  busy,
    output logic                  done,
    output ppsq_pkg::ppsq_out_t   result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);
    import ppsq_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(ID_SPACE);
    localparam int AW = $clog2(3 * QUEUE_DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_TICK   = 8'b0000_1000,
        S_SEARCH = 8'b0001_0000,
        S_SHRD   = 8'b0010_0000,
        S_SHWR   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // One memory holds all three queues: row = queue * depth + slot.
    ppsq_desc_t  dmem [3*QUEUE_DEPTH];
    logic [3:0]  cmem [ID_SPACE];
    ppsq_desc_t  drd_reg;
    logic [3:0]  crd_reg;

    logic [PW-1:0] head_reg [3];
    logic [PW-1:0] tail_reg [3];
    logic [CW-1:0] cnt_reg  [3];

    logic [15:0] node_reg;
    logic [4:0]  cap_reg;
    logic [3:0]  maxs_reg;

    ppsq_in_t    in_reg;
    ppsq_out_t   res_reg, res_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] clr_reg;

    logic        dwe, dre, cwe, cre;
    logic [1:0]  dwq, drq;
    logic [PW-1:0] dwa, dra;
    ppsq_desc_t  dwd;
    logic [IW-1:0] cwa, cra;
    logic [3:0]  cwd;

    logic [1:0]  pq, hq;
    logic [CW:0] capx;
    ppsq_desc_t  ind;
    logic        push_ok;

    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] b, input logic [CW-1:0] o);
        logic [CW:0] s;
        s = {{(CW+1-PW){1'b0}}, b} + {1'b0, o};
        if (s >= (CW+1)'(QUEUE_DEPTH))
            s = s - (CW+1)'(QUEUE_DEPTH);
        return s[PW-1:0];
    endfunction

    function automatic logic [AW-1:0] row(input logic [1:0] q, input logic [PW-1:0] a);
        return AW'(q) * AW'(QUEUE_DEPTH) + AW'(a);
    endfunction

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);

    // pending reflects the queues after the operation has completed.
    always_comb
    begin
        result         = res_reg;
        result.pending = (cnt_reg[0] != '0) || (cnt_reg[1] != '0) || (cnt_reg[2] != '0);
    end

    always_comb
    begin
        ind = '{id: in_reg.pkt_id, kind: in_reg.packet_kind, ttl: in_reg.hop_limit,
                src: in_reg.source_address, dst: in_reg.dest_address,
                slot: in_reg.payload_slot};
        if (in_reg.dest_address != node_reg && in_reg.source_address != node_reg)
            pq = Q_RELAY;
        else if (in_reg.source_address == node_reg && in_reg.dest_address != node_reg)
            pq = (in_reg.packet_kind == KIND_COMMAND) ? Q_COMMAND : Q_RESPONSE;
        else
            pq = Q_NONE;
        capx = (cap_reg > QUEUE_DEPTH) ? (CW+1)'(QUEUE_DEPTH) : (CW+1)'(cap_reg);
        push_ok = (pq != Q_NONE) && ({1'b0, cnt_reg[(pq == Q_NONE) ? Q_RELAY : pq]} < capx);
        if (cnt_reg[0] != '0)      hq = Q_RELAY;
        else if (cnt_reg[1] != '0) hq = Q_RESPONSE;
        else                       hq = Q_COMMAND;
    end

    // Memory port control and next state.
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        dwe = 1'b0; dre = 1'b0; cwe = 1'b0; cre = 1'b0;
        dwq = pq;   dwa = '0;  dwd = ind;
        drq = hq;   dra = head_reg[hq];
        cwa = '0;   cwd = '0;
        cra = IW'(drd_reg.id);
        case (state_reg)
            S_CLEAR:
            begin
                cwe = 1'b1;
                cwa = clr_reg;
                if (clr_reg == IW'(ID_SPACE - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                    idx_next   = '0;
                end
            end
            S_READ:
            begin
                res_next = '0;
                case (in_reg.action)
                    ACT_OFFER:
                    begin
                        if (push_ok)
                        begin
                            dwe = 1'b1;
                            dwa = tail_reg[pq];
                        end
                        res_next.accepted = push_ok;
                        state_next = S_DONE;
                    end
                    ACT_ACK:
                    begin
                        drq = Q_COMMAND;
                        dra = head_reg[2];
                        dre = (cnt_reg[2] != '0);
                        state_next = (cnt_reg[2] != '0) ? S_SEARCH : S_DONE;
                    end
                    ACT_TICK:
                    begin
                        dre = (cnt_reg[0] | cnt_reg[1] | cnt_reg[2]) != '0;
                        state_next = dre ? S_TICK : S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_TICK:
            begin
                // drd_reg holds the head; for command heads read its count first.
                if (hq == Q_COMMAND && idx_reg == '0)
                begin
                    cre = 1'b1;
                    idx_next = CW'(1);
                end
                else
                begin
                    res_next.from_queue  = hq;
                    res_next.out_id      = drd_reg.id;
                    res_next.out_kind    = drd_reg.kind;
                    res_next.out_hop_limit = drd_reg.ttl;
                    res_next.out_source  = drd_reg.src;
                    res_next.out_dest    = drd_reg.dst;
                    res_next.out_slot    = drd_reg.slot;
                    if (hq == Q_RELAY)
                    begin
                        if (drd_reg.ttl > 8'd1)
                        begin
                            res_next.event_res     = EV_SEND;
                            res_next.out_hop_limit = drd_reg.ttl - 8'd1;
                            res_next.out_last_hop  = node_reg;
                        end
                        else
                            res_next.event_res = EV_EXPIRED;
                    end
                    else if (hq == Q_RESPONSE)
                        res_next.event_res = EV_SEND;
                    else
                    begin
                        cwe = 1'b1;
                        cwa = IW'(drd_reg.id);
                        if (crd_reg >= maxs_reg)
                        begin
                            res_next.event_res = EV_ERROR;
                            cwd = '0;
                        end
                        else
                        begin
                            res_next.event_res = EV_SEND;
                            cwd = crd_reg + 4'd1;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                drq = Q_COMMAND;
                if (drd_reg.id == in_reg.acked_id)
                begin
                    res_next.accepted = 1'b1;
                    cwe = 1'b1;
                    cwa = IW'(in_reg.acked_id);
                    cwd = '0;
                    if (idx_reg + CW'(1) < cnt_reg[2])
                    begin
                        dre = 1'b1;
                        dra = wrap(head_reg[2], idx_reg + CW'(1));
                        state_next = S_SHWR;
                    end
                    else
                        state_next = S_DONE;
                end
                else if (idx_reg + CW'(1) < cnt_reg[2])
                begin
                    dre = 1'b1;
                    dra = wrap(head_reg[2], idx_reg + CW'(1));
                    idx_next = idx_reg + CW'(1);
                end
                else
                    state_next = S_DONE;
            end
            S_SHWR:
            begin
                // drd_reg holds entry idx+1; move it down to idx. The count
                // has already dropped by one for the removed entry.
                dwe = 1'b1;
                dwq = Q_COMMAND;
                dwa = wrap(head_reg[2], idx_reg);
                dwd = drd_reg;
                idx_next = idx_reg + CW'(1);
                state_next = (idx_reg + CW'(1) < cnt_reg[2]) ? S_SHRD : S_DONE;
            end
            S_SHRD:
            begin
                drq = Q_COMMAND;
                dre = 1'b1;
                dra = wrap(head_reg[2], idx_reg + CW'(1));
                state_next = S_SHWR;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dwe) dmem[row(dwq, dwa)] <= dwd;
        if (dre) drd_reg <= dmem[row(drq, dra)];
        if (cwe) cmem[cwa] <= cwd;
        if (cre) crd_reg <= cmem[cra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            res_reg   <= '0;
            in_reg    <= '0;
            node_reg  <= '0;
            cap_reg   <= 5'd16;
            maxs_reg  <= 4'd5;
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                cnt_reg[q]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_IDLE && start) in_reg <= operand;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_NODE_ADDRESS:   node_reg <= cfg_data;
                    REG_QUEUE_CAPACITY: cap_reg  <= cfg_data[4:0];
                    REG_MAX_SENDS:      maxs_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (state_reg != S_DONE) res_reg <= res_next;
            // Pointer and count updates for offers, ticks and matched acknowledges.
            if (state_reg == S_READ && in_reg.action == ACT_OFFER && push_ok)
            begin
                tail_reg[pq] <= wrap(tail_reg[pq], CW'(1));
                cnt_reg[pq]  <= cnt_reg[pq] + CW'(1);
            end
            if (state_reg == S_TICK && !(hq == Q_COMMAND && idx_reg == '0))
            begin
                if (hq != Q_COMMAND || crd_reg >= maxs_reg)
                begin
                    head_reg[hq] <= wrap(head_reg[hq], CW'(1));
                    cnt_reg[hq]  <= cnt_reg[hq] - CW'(1);
                end
            end
            if (state_reg == S_SEARCH && drd_reg.id == in_reg.acked_id)
            begin
                tail_reg[2] <= wrap(tail_reg[2], CW'(QUEUE_DEPTH - 1));
                cnt_reg[2]  <= cnt_reg[2] - CW'(1);
            end
        end
    end

endmodule

@@ verif/priority_packet_send_queues_unit_test.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Priority packet send queues unit test
// Drives offers, acknowledges and service ticks through the command port,
// predicts every result beat with a behavioural model of the three queues and
// the per-id send counts, and compares each beat field by field.
//------------------------------------------------------------------------------
module priority_packet_send_queues_unit_test;

    import ppsq_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDS   = ID_SPACE;

    logic       clk;
    logic       rst_n;
    logic       start;
    ppsq_in_t   operand;
    logic       busy;
    logic       done;
    ppsq_out_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    priority_packet_send_queues_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .operand(operand), .busy(busy),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    ppsq_desc_t  queues [3][$];
    logic [3:0]  sends_per_id [IDS];
    logic [15:0] my_node;
    int          cap_limit;
    int          send_limit;
    ppsq_out_t   expected_beats [$];
    int          error_count;
    int          sender_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("Mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic ppsq_out_t predict_step(input ppsq_in_t it);
        ppsq_out_t  r;
        ppsq_desc_t d;
        logic [1:0] q;
        int         cap;
        r   = '0;
        d   = '0;
        q   = Q_NONE;
        cap = cap_limit < DEPTH ? cap_limit : DEPTH;
        if (it.action == ACT_OFFER)
        begin
            d = '{it.pkt_id, it.packet_kind, it.hop_limit, it.source_address,
                  it.dest_address, it.payload_slot};
            if (d.dst != my_node && d.src != my_node)
                q = Q_RELAY;
            else if (d.src == my_node && d.dst != my_node)
                q = (d.kind == KIND_COMMAND) ? Q_COMMAND : Q_RESPONSE;
            if (q != Q_NONE && queues[q].size() < cap)
            begin
                queues[q] = {queues[q], d};
                r.accepted = 1'b1;
            end
        end
        else if (it.action == ACT_ACK)
        begin
            foreach (queues[Q_COMMAND][i])
                if (queues[Q_COMMAND][i].id == it.acked_id)
                begin
                    queues[Q_COMMAND].delete(i);
                    sends_per_id[it.acked_id] = '0;
                    r.accepted = 1'b1;
                    break;
                end
        end
        else if (it.action == ACT_TICK)
        begin
            if (queues[Q_RELAY].size() > 0)
            begin
                d = queues[Q_RELAY][0];
                queues[Q_RELAY].delete(0);
                r.from_queue = Q_RELAY;
                if (d.ttl > 1)
                begin
                    d.ttl = d.ttl - 8'd1;
                    r.event_res = EV_SEND;
                    r.out_last_hop = my_node;
                end
                else
                    r.event_res = EV_EXPIRED;
            end
            else if (queues[Q_RESPONSE].size() > 0)
            begin
                d = queues[Q_RESPONSE][0];
                queues[Q_RESPONSE].delete(0);
                r.from_queue = Q_RESPONSE;
                r.event_res = EV_SEND;
            end
            else if (queues[Q_COMMAND].size() > 0)
            begin
                d = queues[Q_COMMAND][0];
                r.from_queue = Q_COMMAND;
                if (sends_per_id[d.id] >= send_limit)
                begin
                    queues[Q_COMMAND].delete(0);
                    sends_per_id[d.id] = '0;
                    r.event_res = EV_ERROR;
                end
                else
                begin
                    sends_per_id[d.id] = sends_per_id[d.id] + 4'd1;
                    r.event_res = EV_SEND;
                end
            end
            if (r.event_res != EV_NONE)
            begin
                r.out_id = d.id;
                r.out_kind = d.kind;
                r.out_hop_limit = d.ttl;
                r.out_source = d.src;
                r.out_dest = d.dst;
                r.out_slot = d.slot;
            end
        end
        r.pending = (queues[0].size() + queues[1].size() + queues[2].size()) != 0;
        return r;
    endfunction

    // Result checker: every done beat is taken at the edge ending its cycle.
    always @(posedge clk)
    begin
        ppsq_out_t want;
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", 16'(result.out_id), 16'h0000);
            else
            begin
                want = expected_beats[0];
                expected_beats.delete(0);
                if (result.event_res != want.event_res)
                    report_mismatch("event_res", 16'(result.event_res),
                                    16'(want.event_res));
                if (result.from_queue != want.from_queue)
                    report_mismatch("from_queue", 16'(result.from_queue),
                                    16'(want.from_queue));
                if (result.out_id != want.out_id)
                    report_mismatch("out_id", 16'(result.out_id), 16'(want.out_id));
                if (result.out_kind != want.out_kind)
                    report_mismatch("out_kind", 16'(result.out_kind), 16'(want.out_kind));
                if (result.out_hop_limit != want.out_hop_limit)
                    report_mismatch("out_hop_limit", 16'(result.out_hop_limit),
                                    16'(want.out_hop_limit));
                if (result.out_source != want.out_source)
                    report_mismatch("out_source", result.out_source, want.out_source);
                if (result.out_dest != want.out_dest)
                    report_mismatch("out_dest", result.out_dest, want.out_dest);
                if (result.out_last_hop != want.out_last_hop)
                    report_mismatch("out_last_hop", result.out_last_hop, want.out_last_hop);
                if (result.out_slot != want.out_slot)
                    report_mismatch("out_slot", 16'(result.out_slot), 16'(want.out_slot));
                if (result.accepted != want.accepted)
                    report_mismatch("accepted", 16'(result.accepted), 16'(want.accepted));
                if (result.pending != want.pending)
                    report_mismatch("pending", 16'(result.pending), 16'(want.pending));
            end
        end
    end

    // Sends one item; start stays high until the edge at which busy is low.
    task automatic send_item(input ppsq_in_t it);
        int gap;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        operand <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_beats = {expected_beats, predict_step(it)};
        start <= 1'b0;
        // The block is busy for this cycle anyway.
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_beats.size() != 0)
            @(posedge clk);
        // An acknowledge over a full command queue may still be finishing.
        repeat (80) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_NODE_ADDRESS:   my_node = val;
            REG_QUEUE_CAPACITY: cap_limit = int'(val[4:0]);
            REG_MAX_SENDS:      send_limit = int'(val[3:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic ppsq_in_t make_offer(input logic [15:0] src, input logic [15:0] dst,
                                            input logic [1:0] kind, input logic [7:0] id);
        ppsq_in_t it;
        it = '0;
        it.action = ACT_OFFER;
        it.pkt_id = id;
        it.packet_kind = kind;
        it.hop_limit = 8'($urandom);
        it.source_address = src;
        it.dest_address = dst;
        it.payload_slot = 8'($urandom);
        it.acked_id = 8'($urandom);
        return it;
    endfunction

    function automatic ppsq_in_t make_simple(input logic [1:0] act, input logic [7:0] aid);
        ppsq_in_t it;
        it = ppsq_in_t'({$urandom, $urandom, 4'($urandom)});
        it.action = act;
        it.acked_id = aid;
        return it;
    endfunction

    task automatic test_directed();
        ppsq_in_t it;
        logic [15:0] other;
        other = ~my_node;
        // Relay: TTL one and zero expire, TTL of 255.
        it = make_offer(16'h1234, 16'hFFFF, KIND_DATA, 8'h00); it.hop_limit = 8'd1;
        send_item(it);
        it = make_offer(16'hFFFF, 16'h0001, KIND_RESPONSE, 8'hFF); it.hop_limit = 8'd0;
        send_item(it);
        it = make_offer(16'h0001, 16'h1234, KIND_ACK, 8'h5A); it.hop_limit = 8'hFF;
        send_item(it);
        // To this node: not queued.  Both addresses this node: not queued.
        send_item(make_offer(other, my_node, KIND_COMMAND, 8'h11));
        send_item(make_offer(my_node, my_node, KIND_COMMAND, 8'h12));
        // Own packets: response and command.
        send_item(make_offer(my_node, other, KIND_RESPONSE, 8'h21));
        send_item(make_offer(my_node, other, KIND_COMMAND, 8'h22));
        send_item(make_offer(my_node, other, KIND_COMMAND, 8'h23));
        send_item(make_simple(ACT_NONE, 8'h00));
        repeat (3) send_item(make_simple(ACT_TICK, 8'h00));
        send_item(make_simple(ACT_ACK, 8'h23));
        send_item(make_simple(ACT_ACK, 8'h99));
        repeat (8) send_item(make_simple(ACT_TICK, 8'h00));
        send_item(make_simple(ACT_TICK, 8'h00));
    endtask

    // Well-formed traffic between a few addresses, with a bias to command ids
    // that are later acknowledged; the rest is noise.
    task automatic test_random(input int count);
        ppsq_in_t it;
        int       pick;
        logic [15:0] peer;
        repeat (count)
        begin
            pick = $urandom_range(99);
            peer = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            if (peer == my_node)
                peer = ~my_node;
            if (pick < 20)
                it = make_offer(peer, 16'($urandom_range(3)) ^ {16{$urandom_range(1) == 1'b1}},
                                2'($urandom), 8'($urandom_range(15)));
            else if (pick < 45)
                it = make_offer(my_node, peer, 2'($urandom), 8'($urandom_range(15)));
            else if (pick < 58)
                it = make_simple(ACT_ACK, 8'($urandom_range(15)));
            else if (pick < 62)
                it = make_simple(ACT_ACK, 8'($urandom));
            else if (pick < 95)
                it = make_simple(ACT_TICK, 8'h00);
            else
                it = ppsq_in_t'({$urandom, $urandom, 4'($urandom)});
            send_item(it);
        end
    endtask

    task automatic test_configurations();
        write_register(REG_NODE_ADDRESS, 16'h0000);
        sender_idle_pct = 0;
        test_directed();
        test_random(100);
        wait_drained();

        write_register(REG_NODE_ADDRESS, 16'hFFFF);
        write_register(REG_QUEUE_CAPACITY, 16'd1);
        write_register(REG_MAX_SENDS, 16'd1);
        sender_idle_pct = 79;
        test_directed();
        test_random(80);
        wait_drained();

        write_register(REG_NODE_ADDRESS, 16'h0002);
        write_register(REG_QUEUE_CAPACITY, 16'd0);
        write_register(REG_MAX_SENDS, 16'd0);
        sender_idle_pct = 15;
        test_directed();
        test_random(30);
        wait_drained();

        write_register(REG_NODE_ADDRESS, 16'h0001);
        write_register(REG_QUEUE_CAPACITY, 16'd31);
        write_register(REG_MAX_SENDS, 16'd15);
        sender_idle_pct = 0;
        test_random(120);
        wait_drained();

        write_register(REG_NODE_ADDRESS, 16'hA5C3);
        write_register(REG_QUEUE_CAPACITY, 16'd3);
        write_register(REG_MAX_SENDS, 16'd3);
        sender_idle_pct = 79;
        test_random(150);
    endtask

    initial
    begin
        error_count = 0;
        sender_idle_pct = 0;
        my_node = '0;
        cap_limit = 16;
        send_limit = 5;
        foreach (sends_per_id[i])
            sends_per_id[i] = '0;
        rst_n = 1'b0;
        start = 1'b0;
        operand = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_NODE_ADDRESS;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_configurations();
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
